// File: rtl/intlex_pkg.sv
// ----------------------------------------------------------------------------
// intlex_pkg
// shared types, constants and the character classifier of the literal lexer
// ----------------------------------------------------------------------------
package intlex_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int LENGTH_MAX_DEF = 255;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CHAR_W         = 8;
    localparam int COUNT_W        = 8;
    localparam int OUT_VALUE_W    = 64;
    localparam int DIGIT_W        = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [DIGIT_W-1:0] HEX_ALPHA_BASE = 4'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              token_start;
    } t_in_word;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] literal_value;
        logic [COUNT_W-1:0]     token_length;
        logic                   hex_error;
    } t_out_word;

    // classified character as it travels through the queue
    typedef struct packed {
        logic               start;
        logic               sign_ok;
        logic               is_zero;
        logic               is_x;
        logic               is_oct;
        logic               is_dec;
        logic               is_hex;
        logic [DIGIT_W-1:0] digit;
    } t_cls;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_XPFX,
        PH_HEX,
        PH_OCT,
        PH_DEC
    } t_phase;

    function automatic t_cls classify(input logic [CHAR_W-1:0] c, input logic start,
                                      input logic signed_mode);
        t_cls r;
        logic up, lo;
        r.start   = start;
        r.sign_ok = signed_mode && (c == CH_MINUS);
        r.is_zero = (c == CH_ZERO);
        r.is_x    = (c == CH_LO_X);
        r.is_oct  = (c >= CH_ZERO) && (c <= CH_SEVEN);
        r.is_dec  = (c >= CH_ZERO) && (c <= CH_NINE);
        up        = (c >= CH_UP_A) && (c <= CH_UP_F);
        lo        = (c >= CH_LO_A) && (c <= CH_LO_F);
        r.is_hex  = r.is_dec || up || lo;
        if (up) begin
            r.digit = c[DIGIT_W-1:0] - CH_UP_A[DIGIT_W-1:0] + HEX_ALPHA_BASE;
        end else if (lo) begin
            r.digit = c[DIGIT_W-1:0] - CH_LO_A[DIGIT_W-1:0] + HEX_ALPHA_BASE;
        end else begin
            r.digit = c[DIGIT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/intlex_front.sv
// ----------------------------------------------------------------------------
// intlex_front
// accepts input words, holds the mode register and classifies each character
// ----------------------------------------------------------------------------
module intlex_front
    import intlex_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    output logic     o_push,
    output t_cls     o_push_cls,
    input  logic     i_queue_full
);

    logic r_signed_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_wdata;
        end
    end

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;
    assign o_push_cls = classify(i_in_word.char_code, i_in_word.token_start, r_signed_mode);

endmodule

// File: rtl/intlex_queue.sv
// ----------------------------------------------------------------------------
// intlex_queue
// short register queue of classified characters between front and back
// ----------------------------------------------------------------------------
module intlex_queue
    import intlex_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_push_cls,
    output logic o_full,
    output logic o_valid,
    output t_cls o_cls,
    input  logic i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr, n_wptr;
    logic [PtrW-1:0] r_rptr, n_rptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_cls;
        end
    end

endmodule

// File: rtl/intlex_back.sv
// ----------------------------------------------------------------------------
// intlex_back
// scan state machine, radix accumulator and registered result word
// ----------------------------------------------------------------------------
module intlex_back
    import intlex_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int LENGTH_MAX = LENGTH_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls      i_cls,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int LenCap = (LENGTH_MAX < 255) ? LENGTH_MAX : 255;

    t_phase                r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [COUNT_W-1:0]    r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_word, n_out_word;

    t_phase                ph_b;
    logic [VALUE_BITS-1:0] acc_b, dig_ext, sum8, sum10, sum16, fin_val;
    logic [COUNT_W-1:0]    cnt_b, cnt_inc;
    logic                  neg_b;
    logic                  fin, fin_err;
    logic                  pop;

    assign pop     = i_valid && (!r_out_valid || i_out_ready);
    assign o_pop   = pop;

    assign ph_b    = i_cls.start ? PH_START : r_phase;
    assign acc_b   = i_cls.start ? '0 : r_acc;
    assign cnt_b   = i_cls.start ? '0 : r_cnt;
    assign neg_b   = i_cls.start ? 1'b0 : r_neg;
    assign cnt_inc = (cnt_b < COUNT_W'(LenCap)) ? cnt_b + 1'b1 : cnt_b;

    assign dig_ext = VALUE_BITS'(i_cls.digit);
    assign sum8    = (acc_b << 3) | dig_ext;
    assign sum16   = (acc_b << 4) | dig_ext;
    assign sum10   = (acc_b << 3) + (acc_b << 1) + dig_ext;
    assign fin_val = neg_b ? ('0 - acc_b) : acc_b;

    always_comb begin
        n_phase = ph_b;
        n_acc   = acc_b;
        n_cnt   = cnt_b;
        n_neg   = neg_b;
        fin     = 1'b0;
        fin_err = 1'b0;
        unique case (ph_b)
            PH_IDLE: begin
            end
            PH_START, PH_SIGN: begin
                if (ph_b == PH_START && i_cls.sign_ok) begin
                    n_neg   = 1'b1;
                    n_cnt   = cnt_inc;
                    n_phase = PH_SIGN;
                end else if (i_cls.is_zero) begin
                    n_cnt   = cnt_inc;
                    n_phase = PH_ZERO;
                end else if (i_cls.is_dec) begin
                    n_acc   = sum10;
                    n_cnt   = cnt_inc;
                    n_phase = PH_DEC;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_cls.is_x) begin
                    n_cnt   = cnt_inc;
                    n_phase = PH_XPFX;
                end else if (i_cls.is_oct) begin
                    n_acc   = sum8;
                    n_cnt   = cnt_inc;
                    n_phase = PH_OCT;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_XPFX, PH_HEX: begin
                if (i_cls.is_hex) begin
                    n_acc   = sum16;
                    n_cnt   = cnt_inc;
                    n_phase = PH_HEX;
                end else begin
                    fin     = 1'b1;
                    fin_err = (ph_b == PH_XPFX);
                end
            end
            PH_OCT: begin
                if (i_cls.is_oct) begin
                    n_acc = sum8;
                    n_cnt = cnt_inc;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_DEC: begin
                if (i_cls.is_dec) begin
                    n_acc = sum10;
                    n_cnt = cnt_inc;
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (fin) begin
            n_phase = PH_IDLE;
            n_acc   = '0;
            n_cnt   = '0;
            n_neg   = 1'b0;
        end

        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        if (pop && fin) begin
            n_out_valid              = 1'b1;
            n_out_word.literal_value = OUT_VALUE_W'(fin_val);
            n_out_word.token_length  = cnt_b;
            n_out_word.hex_error     = fin_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_neg   <= n_neg;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: rtl/integer_literal_lexer.sv
// ----------------------------------------------------------------------------
// integer_literal_lexer
// streaming lexer for c-style decimal, octal and hex integer literals
//
//   channel   signals                              carries
//   in        i_in_valid / o_in_ready / i_in_word   one character per word
//   out       o_out_valid / i_out_ready / o_out_word one literal per word
//   cfg       i_cfg_we / i_cfg_wdata               signed mode bit
//
// one character per cycle sustained while the output is not stalled; the
// radix multiply-add of the back end sets that figure. a result word is
// registered in the cycle after the back end takes its terminating
// character. a two-word queue separates front and back; a stalled output
// holds the back end and the queue absorbs up to two more characters.
// reset is synchronous and leaves signed mode on.
// ----------------------------------------------------------------------------
module integer_literal_lexer
    import intlex_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int LENGTH_MAX = LENGTH_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic push, full, q_valid, pop;
    t_cls push_cls, q_cls;

    intlex_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_push       (push),
        .o_push_cls   (push_cls),
        .i_queue_full (full)
    );

    intlex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cls (push_cls),
        .o_full     (full),
        .o_valid    (q_valid),
        .o_cls      (q_cls),
        .i_pop      (pop)
    );

    intlex_back #(
        .VALUE_BITS (VALUE_BITS),
        .LENGTH_MAX (LENGTH_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cls       (q_cls),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// File: rtl/intlex_checker.sv
// ----------------------------------------------------------------------------
// intlex_checker
// port-level checks on the literal lexer, bound to the top level
// ----------------------------------------------------------------------------
module intlex_checker
    import intlex_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    a_rst_no_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_hex_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.hex_error |->
            o_out_word.literal_value == '0 && o_out_word.token_length >= 8'd2)
        else $error("empty hex prefix with value or short length");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.token_length == '0 |->
            o_out_word.literal_value == '0 && !o_out_word.hex_error)
        else $error("empty literal with value or error");

endmodule

bind integer_literal_lexer intlex_checker u_chk (.*);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the integer literal lexer: a character stream of
// directed and random literals goes in, a local scanner predicts each parsed
// value, length and hex error flag, and every output word is compared in order
// ----------------------------------------------------------------------------
module tb_top
    import intlex_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT      = 32;
    localparam int RADIX_OCT     = 8;
    localparam int RADIX_DEC     = 10;
    localparam int RADIX_HEX     = 16;
    localparam int LEN_CAP       = (LENGTH_MAX_DEF < 255) ? LENGTH_MAX_DEF : 255;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AT       = 10;
    localparam int HOLD_LEN      = 120;
    localparam int PHASE_CHARS   = 50;
    localparam int MAX_SHOWN     = 10;
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // scanner state
    t_phase      scan_ph   = PH_IDLE;
    logic [63:0] acc_val   = '0;
    logic [7:0]  char_cnt  = '0;
    logic        neg_seen  = 1'b0;
    logic        sign_mode = 1'b1;

    t_in_word  char_q[$];
    t_out_word literal_q[$];
    int  idle_pct     = IDLE_PCT;
    int  n_queued     = 0;
    int  n_chars      = 0;
    int  n_checked    = 0;
    int  n_fail       = 0;
    int  n_hex_err    = 0;
    int  n_saturated  = 0;
    int  hold_cnt     = 0;
    bit  held         = 1'b0;
    bit  lead_pending = 1'b0;

    integer_literal_lexer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic void count_char();
        if (char_cnt < LEN_CAP) begin
            char_cnt++;
        end
    endfunction

    function automatic void take_digit(input int radix, input int d, input t_phase nxt);
        acc_val = acc_val * radix + d;
        count_char();
        scan_ph = nxt;
    endfunction

    function automatic void emit_literal(input logic err);
        t_out_word w;
        w.literal_value = neg_seen ? -acc_val : acc_val;
        w.token_length  = char_cnt;
        w.hex_error     = err;
        literal_q.push_back(w);
        scan_ph  = PH_IDLE;
        acc_val  = '0;
        char_cnt = '0;
        neg_seen = 1'b0;
    endfunction

    // advances the scanner by one accepted character
    function automatic void scan_char(input t_in_word w);
        logic [7:0] c;
        int         hv;
        c  = w.char_code;
        hv = -1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            hv = int'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            hv = int'(c - CH_UP_A) + RADIX_DEC;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            hv = int'(c - CH_LO_A) + RADIX_DEC;
        end
        if (w.token_start) begin
            scan_ph  = PH_START;
            acc_val  = '0;
            char_cnt = '0;
            neg_seen = 1'b0;
        end
        case (scan_ph)
            PH_START, PH_SIGN: begin
                if (scan_ph == PH_START && sign_mode && c == CH_MINUS) begin
                    neg_seen = 1'b1;
                    count_char();
                    scan_ph = PH_SIGN;
                end else if (c == CH_ZERO) begin
                    count_char();
                    scan_ph = PH_ZERO;
                end else if (c > CH_ZERO && c <= CH_NINE) begin
                    take_digit(RADIX_DEC, hv, PH_DEC);
                end else begin
                    emit_literal(1'b0);
                end
            end
            PH_ZERO: begin
                if (c == CH_LO_X) begin
                    count_char();
                    scan_ph = PH_XPFX;
                end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    take_digit(RADIX_OCT, hv, PH_OCT);
                end else begin
                    emit_literal(1'b0);
                end
            end
            PH_XPFX, PH_HEX: begin
                if (hv >= 0) begin
                    take_digit(RADIX_HEX, hv, PH_HEX);
                end else begin
                    emit_literal(scan_ph == PH_XPFX);
                end
            end
            PH_OCT: begin
                if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    take_digit(RADIX_OCT, hv, PH_OCT);
                end else begin
                    emit_literal(1'b0);
                end
            end
            PH_DEC: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    take_digit(RADIX_DEC, hv, PH_DEC);
                end else begin
                    emit_literal(1'b0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // driver
    always @(posedge clk) begin
        logic holding;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            holding = in_valid && !in_ready;
            if (in_valid && in_ready) begin
                scan_char(in_word);
                n_chars++;
            end
            if (!holding) begin
                if (char_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_word  <= char_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void note_fail(input string msg);
        n_fail++;
        if (n_fail <= MAX_SHOWN) begin
            $display("%s", msg);
        end
    endfunction

    // monitor
    always @(posedge clk) begin
        t_out_word want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (literal_q.size() == 0) begin
                    note_fail($sformatf("unexpected word: value %h length %0d hex_error %0b",
                        out_word.literal_value, out_word.token_length, out_word.hex_error));
                end else begin
                    want = literal_q.pop_front();
                    n_checked++;
                    if (want.hex_error) begin
                        n_hex_err++;
                    end
                    if (want.token_length == LEN_CAP) begin
                        n_saturated++;
                    end
                    if (out_word.literal_value !== want.literal_value ||
                        out_word.token_length !== want.token_length ||
                        out_word.hex_error !== want.hex_error) begin
                        note_fail($sformatf({"mismatch on literal %0d: ",
                            "value %h/%h length %0d/%0d hex_error %0b/%0b (exp/got)"},
                            n_checked, want.literal_value, out_word.literal_value,
                            want.token_length, out_word.token_length,
                            want.hex_error, out_word.hex_error));
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (!held && n_checked == HOLD_AT) begin
                held     = 1'b1;
                hold_cnt = HOLD_LEN;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // stimulus helpers
    function automatic void put(input logic [7:0] c);
        t_in_word w;
        w.char_code   = c;
        w.token_start = lead_pending;
        lead_pending  = 1'b0;
        char_q.push_back(w);
        n_queued++;
    endfunction

    function automatic void put_text(input string s);
        lead_pending = 1'b1;
        for (int i = 0; i < s.len(); i++) begin
            put(s[i]);
        end
    endfunction

    function automatic void put_long(input int radix, input int ndig);
        lead_pending = 1'b1;
        if (radix == RADIX_HEX) begin
            put(CH_ZERO);
            put(CH_LO_X);
        end
        for (int i = 0; i < ndig; i++) begin
            if (radix == RADIX_HEX) begin
                put(HEX_DIGITS[$urandom_range(0, 21)]);
            end else begin
                put(8'(CH_ZERO + $urandom_range(1, 9)));
            end
        end
        put(" ");
    endfunction

    function automatic void put_random_literal();
        int kind;
        int ndig;
        kind = $urandom_range(0, 9);
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        lead_pending = 1'b1;
        if (kind == 9) begin
            for (int i = 0; i < ndig; i++) begin
                lead_pending = $urandom_range(0, 3) == 0;
                put(8'($urandom_range(0, 255)));
            end
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            put(CH_MINUS);
        end
        if (kind < 3) begin
            put(8'(CH_ZERO + $urandom_range(1, 9)));
            for (int i = 1; i < ndig; i++) begin
                put(8'(CH_ZERO + $urandom_range(0, 9)));
            end
        end else if (kind < 5) begin
            put(CH_ZERO);
            ndig = $urandom_range(0, 3) == 0 ? 0 : ndig;
            for (int i = 0; i < ndig; i++) begin
                put(8'(CH_ZERO + $urandom_range(0, 7)));
            end
        end else begin
            put(CH_ZERO);
            put(CH_LO_X);
            if (kind < 8) begin
                for (int i = 0; i < ndig; i++) begin
                    put(HEX_DIGITS[$urandom_range(0, 21)]);
                end
            end
        end
        // leave some literals open so the next one restarts them
        if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 4))
                0: put(" ");
                1: put(8'h00);
                2: put(8'hff);
                3: put(",");
                default: put(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 9) == 0) begin
                put(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic settle();
        while (n_chars != n_queued) @(posedge clk);
        while (literal_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sign_mode = v;
    endtask

    task automatic random_phase(input int nchars);
        int target;
        target = n_queued + nchars;
        while (n_queued < target) begin
            put_random_literal();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(1'b1);

        // directed
        put_text("-9z");
        put_text("-x");
        put_text("x");
        put(8'hff);
        put_text("09");
        put_text("0x!");
        put_text("0x7fA,");
        put_text("017");
        put(8'h00);
        put_text("12");
        put_text("5 ");
        settle();

        write_mode(1'b0);
        random_phase(PHASE_CHARS);
        settle();

        write_mode(1'b1);
        idle_pct = 0;
        put_long(RADIX_HEX, 270);
        random_phase(PHASE_CHARS);
        settle();

        idle_pct = IDLE_PCT;
        put_long(RADIX_DEC, 300);
        random_phase(PHASE_CHARS);
        settle();

        n_fail += literal_q.size();
        $display("covered %0d characters and %0d literals in both sign modes:",
                 n_chars, n_checked);
        $display("%0d empty hex prefixes, %0d saturated lengths, an output stall and a gapless run",
                 n_hex_err, n_saturated);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
